// File: src/pst_pkg.sv
`default_nettype none

package pst_pkg;

    // Largest index the table can hold; the memory has MAX_LIMIT + 1 entries.
    localparam int unsigned MAX_LIMIT = 65535;

    localparam int unsigned IDX_W  = 16;   // index and limit width
    localparam int unsigned ROOT_W = 9;    // outer sieve counter, up to sqrt(MAX_LIMIT) + 1
    localparam int unsigned SQ_W   = 17;   // square of the outer counter, multiples walk

    localparam logic [IDX_W-1:0] LIMIT_RESET = IDX_W'(MAX_LIMIT);
    localparam int unsigned FIRST_PRIME = 2;

    // Command queue between the front and back parts.
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = 1;
    localparam int unsigned QCNT_W  = 2;

    // Configuration port.
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    typedef enum logic {
        OP_BUILD = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    // Register index, taken from byte address bit 2.
    typedef enum logic {
        REG_UPPER_LIMIT = 1'b0,
        REG_NONE        = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic             is_build;
        logic [IDX_W-1:0] index;
    } t_cmd;

endpackage

`default_nettype wire

// File: src/pst_if.sv
`default_nettype none

interface pst_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [pst_pkg::IDX_W-1:0]   query_index;

    modport source (output valid, output opcode, output query_index, input ready);
    modport sink   (input valid, input opcode, input query_index, output ready);
endinterface

interface pst_out_if;
    logic valid;
    logic ready;
    logic is_prime;
    logic answer_valid;

    modport source (output valid, output is_prime, output answer_valid, input ready);
    modport sink   (input valid, input is_prime, input answer_valid, output ready);
endinterface

`default_nettype wire

// File: src/pst_front.sv
`default_nettype none

module pst_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pst_in_if.sink           i_in,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready,
    output pst_pkg::t_cmd    o_cmd
);
    import pst_pkg::*;

    t_cmd               r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_cnt;
    logic [QCNT_W-1:0]  n_cnt;
    logic               push;
    logic               pop;
    t_cmd               cmd_in;

    // Words are only taken out of reset so that nothing is lost to the reset branch.
    assign i_in.ready  = (r_cnt != QCNT_W'(QDEPTH)) && i_rst_n;
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rd_ptr];

    // Classify the incoming word into a build or a query command.
    always_comb begin
        cmd_in.is_build = (t_opcode'(i_in.opcode) == OP_BUILD);
        cmd_in.index    = i_in.query_index;
    end

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

`default_nettype wire

// File: src/pst_back.sv
`default_nettype none

module pst_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    output logic                       o_cmd_ready,
    input  wire pst_pkg::t_cmd         i_cmd,
    input  wire logic [pst_pkg::IDX_W-1:0] i_upper_limit,
    pst_out_if.source                  o_out
);
    import pst_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FILL  = 7'b0000010,
        S_TEST  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_MARK  = 7'b0010000,
        S_QRD   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_addr, n_addr;
    logic [IDX_W-1:0]   r_lim, n_lim;
    logic [ROOT_W-1:0]  r_i, n_i;
    logic [SQ_W-1:0]    r_sq, n_sq;
    logic [SQ_W-1:0]    r_j, n_j;
    logic               r_built, n_built;
    logic [IDX_W-1:0]   r_built_lim, n_built_lim;
    logic               r_out_valid, n_out_valid;
    logic               r_out_prime, n_out_prime;
    logic               r_out_ans, n_out_ans;

    logic               r_mem [0:MAX_LIMIT];
    logic               r_rd;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic               mem_wd;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_ra;

    logic               out_free;
    logic [SQ_W-1:0]    lim_ext;

    assign out_free       = !r_out_valid || o_out.ready;
    assign lim_ext        = SQ_W'(r_lim);
    assign o_out.valid    = r_out_valid;
    assign o_out.is_prime = r_out_prime;
    assign o_out.answer_valid = r_out_ans;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_lim       = r_lim;
        n_i         = r_i;
        n_sq        = r_sq;
        n_j         = r_j;
        n_built     = r_built;
        n_built_lim = r_built_lim;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_prime = r_out_prime;
        n_out_ans   = r_out_ans;
        mem_we      = 1'b0;
        mem_wa      = r_addr;
        mem_wd      = 1'b0;
        mem_re      = 1'b0;
        mem_ra      = i_cmd.index;
        o_cmd_ready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_cmd_ready = out_free;
                if (i_cmd_valid && out_free) begin
                    if (i_cmd.is_build) begin
                        n_lim   = i_upper_limit;
                        n_addr  = '0;
                        n_state = S_FILL;
                    end else if (r_built && (i_cmd.index <= r_built_lim)) begin
                        mem_re  = 1'b1;
                        mem_ra  = i_cmd.index;
                        n_state = S_QRD;
                    end else begin
                        n_out_valid = 1'b1;
                        n_out_prime = 1'b0;
                        n_out_ans   = 1'b0;
                    end
                end
            end
            S_FILL: begin
                // Entries 0 and 1 are written as not prime, all others as candidates.
                mem_we = 1'b1;
                mem_wa = r_addr;
                mem_wd = (r_addr >= IDX_W'(FIRST_PRIME));
                if (r_addr == r_lim) begin
                    n_i     = ROOT_W'(FIRST_PRIME);
                    n_sq    = SQ_W'(FIRST_PRIME * FIRST_PRIME);
                    n_state = S_TEST;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            S_TEST: begin
                if (r_sq > lim_ext) begin
                    n_state = S_FIN;
                end else begin
                    mem_re  = 1'b1;
                    mem_ra  = IDX_W'(r_i);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_rd) begin
                    n_j     = r_sq;
                    n_state = S_MARK;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_sq    = r_sq + SQ_W'({r_i, 1'b1});
                    n_state = S_TEST;
                end
            end
            S_MARK: begin
                if (r_j <= lim_ext) begin
                    mem_we = 1'b1;
                    mem_wa = r_j[IDX_W-1:0];
                    mem_wd = 1'b0;
                    n_j    = r_j + SQ_W'(r_i);
                end else begin
                    // (i+1)^2 = i^2 + 2i + 1
                    n_i     = r_i + 1'b1;
                    n_sq    = r_sq + SQ_W'({r_i, 1'b1});
                    n_state = S_TEST;
                end
            end
            S_QRD: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_rd;
                    n_out_ans   = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_prime = 1'b0;
                    n_out_ans   = 1'b1;
                    n_built     = 1'b1;
                    n_built_lim = r_lim;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_built     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_built     <= n_built;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_lim       <= n_lim;
        r_i         <= n_i;
        r_sq        <= n_sq;
        r_j         <= n_j;
        r_built_lim <= n_built_lim;
        r_out_prime <= n_out_prime;
        r_out_ans   <= n_out_ans;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

endmodule

`default_nettype wire

// File: src/prime_sieve_table.sv
// Query: an accepted input word is written into the queue; the back part pops it,
// reads the table into a register and then loads the output register. A refused
// query skips the table read. The back part takes no new command during a table read.
// Build: every entry up to L is filled, then each outer index up to sqrt(L) is tested
// and its multiples are cleared, one table access at a time.
// Reset is synchronous and active low: it empties the queue and the output register,
// marks the table as not built and sets upper_limit to 65535. The table needs no clearing.
`default_nettype none

module prime_sieve_table (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    pst_in_if.sink                        i_in,
    pst_out_if.source                     o_out,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [pst_pkg::APB_AW-1:0] paddr,
    input  wire logic [pst_pkg::APB_DW-1:0] pwdata,
    output logic [pst_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);
    import pst_pkg::*;

    // The front part takes input words and turns them into build or query
    // commands held in a short queue. The back part owns the one-bit table and
    // the sieve sequencer, and pops a command only when its output register
    // can take the result, so either side can stall without blocking the other.

    logic             r_upper_limit;
    logic [IDX_W-1:0] r_limit;
    logic             cmd_valid;
    logic             cmd_ready;
    t_cmd             cmd;
    logic             cfg_wr;
    t_reg_idx         reg_idx;

    // Configuration port. Only address bit 2 selects a register; the single
    // register sits at byte address zero. A build samples the limit when it starts.
    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (cfg_wr && (reg_idx == REG_UPPER_LIMIT)) begin
            r_limit <= pwdata[IDX_W-1:0];
        end
    end

    // Tracks that the limit register was written on the last edge, for the check below.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_limit <= 1'b0;
        end else begin
            r_upper_limit <= cfg_wr && (reg_idx == REG_UPPER_LIMIT);
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_UPPER_LIMIT: prdata = APB_DW'(r_limit);
            REG_NONE:        prdata = '0;
            default:         prdata = '0;
        endcase
    end

    pst_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    pst_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (cmd_valid),
        .o_cmd_ready   (cmd_ready),
        .i_cmd         (cmd),
        .i_upper_limit (r_limit),
        .o_out         (o_out)
    );

    // A word that was not answered never claims a prime.
    a_invalid_not_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.answer_valid |-> !o_out.is_prime)
        else $error("invalid answer carries a prime flag");

    // The back part only takes a command when its output slot is free.
    a_pop_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid && cmd_ready |-> !(o_out.valid && !o_out.ready))
        else $error("command taken while output is stalled");

    // After an accepted input word, the queue holds at least one command.
    a_word_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> cmd_valid)
        else $error("accepted word did not reach the queue");

    // A write to the limit register lands with the written data.
    a_limit_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upper_limit |-> (r_limit == $past(pwdata[IDX_W-1:0])))
        else $error("limit register write lost");

endmodule

`default_nettype wire
